FILE: rtl/core/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and codes of the three-class priority queue
// Function, class, status and register codes plus the control structs that
// pass between the top level and each ring.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

   localparam int NUM_CLASSES = 3;
   localparam int FUNC_W      = 2;
   localparam int CLASS_W     = 2;
   localparam int STATUS_W    = 2;
   localparam int CFG_W       = 5;
   localparam int CSR_IDX_W   = 2;

   typedef logic [FUNC_W-1:0]    func_type;
   typedef logic [CLASS_W-1:0]   class_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CFG_W-1:0]     depth_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam func_type FUNC_PUT   = 2'd0;
   localparam func_type FUNC_GET   = 2'd1;
   localparam func_type FUNC_QUERY = 2'd2;

   localparam class_type CLASS_HIGH   = 2'd0;
   localparam class_type CLASS_MEDIUM = 2'd1;
   localparam class_type CLASS_LOW    = 2'd2;

   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   localparam csr_idx_type REG_HIGH_DEPTH   = 2'd0;
   localparam csr_idx_type REG_MEDIUM_DEPTH = 2'd1;
   localparam csr_idx_type REG_LOW_DEPTH    = 2'd2;

   localparam depth_type DEPTH_RESET = 5'd16;

   // Per-ring operation for the current step
   typedef struct packed {
      logic push;
      logic pop;
   } ring_cmd_type;

   // Per-ring state flags, now and after the current step
   typedef struct packed {
      logic empty;
      logic full;
      logic empty_after;
      logic full_after;
   } ring_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/tcpq_ifs.sv
// ----------------------------------------------------------------------------
// tcpq_ifs: channel interfaces of the three-class priority queue
// Request, response and register-write channels, each with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcpq_req_if #(
   parameter int WORD_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic [tcpq_pkg::FUNC_W-1:0]  func;
   logic [tcpq_pkg::CLASS_W-1:0] class_sel;
   logic [WORD_WIDTH-1:0]        data_in;

   modport source (output valid, output func, output class_sel, output data_in,
                   input ready);
   modport sink   (input valid, input func, input class_sel, input data_in,
                   output ready);
endinterface

interface tcpq_rsp_if #(
   parameter int WORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic [tcpq_pkg::STATUS_W-1:0] status;
   logic [WORD_WIDTH-1:0]         data_out;
   logic [tcpq_pkg::CLASS_W-1:0]  served_class;
   logic                          all_empty;
   logic                          class_full;

   modport source (output valid, output status, output data_out, output served_class,
                   output all_empty, output class_full, input ready);
   modport sink   (input valid, input status, input data_out, input served_class,
                   input all_empty, input class_full, output ready);
endinterface

interface tcpq_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tcpq_pkg::CSR_IDX_W-1:0] index;
   logic [tcpq_pkg::CFG_W-1:0]     wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tcpq_ring.sv
// ----------------------------------------------------------------------------
// tcpq_ring: one ring buffer of the priority queue
// Storage memory, write/read pointers that wrap at the configured depth, an
// occupancy count, and a registered head word prefetched at the read pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ring #(
   parameter int RING_DEPTH = 16,
   parameter int WORD_WIDTH = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [tcpq_pkg::CFG_W-1:0]    depth_cfg,
   input  wire tcpq_pkg::ring_cmd_type  cmd,
   input  wire [WORD_WIDTH-1:0]         wdata,
   output logic [WORD_WIDTH-1:0]        head,
   output tcpq_pkg::ring_stat_type      stat
);
   import tcpq_pkg::*;

   localparam int PW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int DW = (CW > CFG_W) ? CW : CFG_W;

   logic [WORD_WIDTH-1:0] mem [RING_DEPTH];
   logic [WORD_WIDTH-1:0] head_ff;
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DW-1:0]         depth_ext;
   logic [CW-1:0]         eff_depth;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p,
                                              input logic [CW-1:0] depth);
      logic [CW-1:0] n;
      n = CW'(p) + CW'(1);
      return (n >= depth) ? '0 : n[PW-1:0];
   endfunction

   // Clamp the configured depth to 1..RING_DEPTH
   always_comb begin
      depth_ext = DW'(depth_cfg);
      if (depth_ext == '0) begin
         depth_ext = DW'(1);
      end else if (depth_ext > DW'(RING_DEPTH)) begin
         depth_ext = DW'(RING_DEPTH);
      end
      eff_depth = depth_ext[CW-1:0];
   end

   always_comb begin
      wr_ptr_in = cmd.push ? ptr_next(wr_ptr_ff, eff_depth) : wr_ptr_ff;
      rd_ptr_in = cmd.pop  ? ptr_next(rd_ptr_ff, eff_depth) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (cmd.push) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.pop) begin
         cnt_in = cnt_ff - CW'(1);
      end
      if (reset) begin
         rd_ptr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage write, and head prefetch with bypass of a same-address write
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_ptr_ff] <= wdata;
      end
      if (cmd.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= wdata;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   assign head             = head_ff;
   assign stat.empty       = (cnt_ff == '0);
   assign stat.full        = (cnt_ff >= eff_depth);
   assign stat.empty_after = (cnt_in == '0);
   assign stat.full_after  = (cnt_in >= eff_depth);

endmodule

`default_nettype wire

FILE: rtl/core/three_class_priority_queue.sv
// ----------------------------------------------------------------------------
// three_class_priority_queue: strict-priority queue over three ring buffers
// Put, get and status requests against high, medium and low rings.
// ----------------------------------------------------------------------------
// One request is taken every clock while no stalled response holds the input.
// A request is held in an input register, then a single pass over the three
// rings' pointers and counts decides the step and loads the response register,
// so each response passes the input register and then the response register.
// A stalled response still lets one more request into the input register;
// after that the input stalls until the response transfers. The ring memories
// are read through a registered head word prefetched at each read pointer,
// which keeps a get to one memory read per ring per cycle. Ring depths are
// written through the csr channel (always ready); the user must write them only
// while the block is idle, which the block itself does not enforce. A new depth
// takes effect at once in the full flags and the pointer wrap. There is no
// clearing pass: rings start empty after reset.
`default_nettype none

module three_class_priority_queue #(
   parameter int RING_DEPTH = 16,
   parameter int WORD_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   tcpq_req_if.sink    req_chan,
   tcpq_rsp_if.source  rsp_chan,
   tcpq_csr_if.sink    csr_chan
);
   import tcpq_pkg::*;

   // Configuration
   depth_type depth_ff [NUM_CLASSES];

   // Input register
   logic                  q_vld_ff, q_vld_in;
   func_type              q_func_ff;
   class_type             q_sel_ff;
   logic [WORD_WIDTH-1:0] q_data_ff;

   // Response register
   logic                  rsp_vld_ff, rsp_vld_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [WORD_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   class_type             rsp_served_ff, rsp_served_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_full_ff, rsp_full_in;

   logic                  req_fire, adv;
   logic                  is_put, is_get, found;
   logic                  sel_full, sel_full_after;
   ring_cmd_type          cmd  [NUM_CLASSES];
   ring_stat_type         stat [NUM_CLASSES];
   logic [WORD_WIDTH-1:0] head [NUM_CLASSES];

   assign adv            = q_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !q_vld_ff || adv;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            depth_ff[c] <= DEPTH_RESET;
         end
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_HIGH_DEPTH:   depth_ff[0] <= csr_chan.wdata;
            REG_MEDIUM_DEPTH: depth_ff[1] <= csr_chan.wdata;
            REG_LOW_DEPTH:    depth_ff[2] <= csr_chan.wdata;
            default: ;
         endcase
      end
   end

   generate
      for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_ring
         tcpq_ring #(
            .RING_DEPTH (RING_DEPTH),
            .WORD_WIDTH (WORD_WIDTH)
         ) u_ring (
            .clock     (clock),
            .reset     (reset),
            .depth_cfg (depth_ff[g]),
            .cmd       (cmd[g]),
            .wdata     (q_data_ff),
            .head      (head[g]),
            .stat      (stat[g])
         );
      end
   endgenerate

   // Step decode: push to the named class, pop from the first non-empty class
   always_comb begin
      is_put = (q_func_ff == FUNC_PUT);
      is_get = (q_func_ff == FUNC_GET);
      found  = 1'b0;
      rsp_data_in   = '0;
      rsp_served_in = CLASS_HIGH;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         cmd[c].push = adv && is_put && (q_sel_ff == CLASS_W'(c)) && !stat[c].full;
         cmd[c].pop  = adv && is_get && !found && !stat[c].empty;
         if (is_get && !found && !stat[c].empty) begin
            found         = 1'b1;
            rsp_data_in   = head[c];
            rsp_served_in = CLASS_W'(c);
         end
      end
   end

   always_comb begin
      unique case (q_sel_ff)
         CLASS_HIGH: begin
            sel_full       = stat[0].full;
            sel_full_after = stat[0].full_after;
         end
         CLASS_MEDIUM: begin
            sel_full       = stat[1].full;
            sel_full_after = stat[1].full_after;
         end
         CLASS_LOW: begin
            sel_full       = stat[2].full;
            sel_full_after = stat[2].full_after;
         end
         default: begin
            // no such class: always reads as full
            sel_full       = 1'b1;
            sel_full_after = 1'b1;
         end
      endcase

      rsp_status_in = STATUS_DONE;
      if (is_put && sel_full) begin
         rsp_status_in = STATUS_FULL;
      end else if (is_get && !found) begin
         rsp_status_in = STATUS_EMPTY;
      end
      rsp_empty_in = stat[0].empty_after && stat[1].empty_after && stat[2].empty_after;
      rsp_full_in  = sel_full_after;
   end

   always_comb begin
      q_vld_in = q_vld_ff;
      if (req_fire) begin
         q_vld_in = 1'b1;
      end else if (adv) begin
         q_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         q_vld_ff   <= q_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         q_func_ff <= req_chan.func;
         q_sel_ff  <= req_chan.class_sel;
         q_data_ff <= req_chan.data_in;
      end
      if (adv) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_served_ff <= rsp_served_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_full_ff   <= rsp_full_in;
      end
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.data_out     = rsp_data_ff;
   assign rsp_chan.served_class = rsp_served_ff;
   assign rsp_chan.all_empty    = rsp_empty_ff;
   assign rsp_chan.class_full   = rsp_full_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tcpq_checker.sv
// ----------------------------------------------------------------------------
// tcpq_checker: port-level checks for the three-class priority queue
// Watches the response channel for consistency between its fields and for
// correct behavior across reset and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_checker #(
   parameter int WORD_WIDTH = 32
) (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [tcpq_pkg::STATUS_W-1:0] rsp_status,
   input wire [WORD_WIDTH-1:0]         rsp_data_out,
   input wire                          rsp_all_empty,
   input wire                          rsp_class_full
);
   import tcpq_pkg::*;

   // a stalled response stays valid and holds its status and data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data_out))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_empty_get: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> rsp_all_empty)
      else $error("empty get while queue holds data");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_class_full)
      else $error("rejected put on a class not full");

   a_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_DONE) |-> (rsp_data_out == '0))
      else $error("data on a failed request");

endmodule

bind three_class_priority_queue tcpq_checker #(
   .WORD_WIDTH (WORD_WIDTH)
) u_tcpq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_data_out   (rsp_chan.data_out),
   .rsp_all_empty  (rsp_chan.all_empty),
   .rsp_class_full (rsp_chan.class_full)
);

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the three-class priority queue
// Drives put, get and status requests with random idling and a long response
// stall, predicts every response from a local copy of the three rings, and
// compares each response transfer in order. Ring depths are changed between
// traffic phases, including out-of-range settings.
// ----------------------------------------------------------------------------

module tb_top;

   import tcpq_pkg::*;

   localparam int RING_DEPTH  = 16;
   localparam int WORD_W      = 32;
   localparam int STALL_LIMIT = 2000;
   localparam int SHOW_LIMIT  = 40;

   // Codes that the package leaves unnamed
   localparam func_type  FUNC_ALT_QUERY = 2'd3;
   localparam class_type CLASS_NONE     = 2'd3;

   // Two copies of the ring model: one steers stimulus, one checks responses
   localparam int GEN = 0;
   localparam int CHK = 1;

   typedef struct packed {
      func_type            func;
      class_type           class_sel;
      logic [WORD_W-1:0]   data;
   } queue_op_type;

   typedef struct packed {
      status_type          status;
      logic [WORD_W-1:0]   data;
      class_type           served;
      logic                all_empty;
      logic                class_full;
   } queue_reply_type;

   logic clock = 1'b0;
   logic reset;

   tcpq_req_if #(.WORD_WIDTH(WORD_W)) req_bus ();
   tcpq_rsp_if #(.WORD_WIDTH(WORD_W)) rsp_bus ();
   tcpq_csr_if                        csr_bus ();

   three_class_priority_queue #(
      .RING_DEPTH (RING_DEPTH),
      .WORD_WIDTH (WORD_W)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Ring model state
   logic [WORD_W-1:0] ring_mem     [2][NUM_CLASSES][RING_DEPTH];
   bit                ring_written [2][NUM_CLASSES][RING_DEPTH];
   int unsigned       wr_ptr       [2][NUM_CLASSES];
   int unsigned       rd_ptr       [2][NUM_CLASSES];
   int unsigned       fill         [2][NUM_CLASSES];
   depth_type         depth_reg    [2][NUM_CLASSES];

   queue_op_type    op_backlog[$];
   queue_reply_type predicted_replies[$];

   int  issued;
   int  req_count;
   int  replies_seen;
   int  csr_writes;
   int  mismatches;
   int  stall_cycles;
   bit  req_taken;
   bit  steady;
   bit  rsp_hold;

   queue_op_type    monitor_op;
   queue_op_type    drive_op;
   queue_reply_type want;

   function automatic int unsigned eff_depth(int v, int c);
      int unsigned d;
      d = depth_reg[v][c];
      if (d == 0) d = 1;
      if (d > RING_DEPTH) d = RING_DEPTH;
      return d;
   endfunction

   function automatic bit ring_full(int v, int c);
      return fill[v][c] >= eff_depth(v, c);
   endfunction

   function automatic int unsigned ptr_advance(int unsigned p, int unsigned d);
      return (p + 1 >= d) ? 0 : p + 1;
   endfunction

   // Step one copy of the model by one request and return its response
   function automatic queue_reply_type apply_queue_op(int v, queue_op_type op);
      queue_reply_type reply;
      bit              served;
      int              sel;
      reply  = '0;
      served = 1'b0;
      sel    = op.class_sel;
      if (op.func == FUNC_PUT) begin
         if (op.class_sel > CLASS_LOW || ring_full(v, sel)) begin
            reply.status = STATUS_FULL;
         end else begin
            ring_mem[v][sel][wr_ptr[v][sel]]     = op.data;
            ring_written[v][sel][wr_ptr[v][sel]] = 1'b1;
            wr_ptr[v][sel] = ptr_advance(wr_ptr[v][sel], eff_depth(v, sel));
            fill[v][sel]++;
         end
      end else if (op.func == FUNC_GET) begin
         reply.status = STATUS_EMPTY;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            if (!served && fill[v][c] != 0) begin
               reply.data   = ring_mem[v][c][rd_ptr[v][c]];
               rd_ptr[v][c] = ptr_advance(rd_ptr[v][c], eff_depth(v, c));
               fill[v][c]--;
               reply.served = class_type'(c);
               reply.status = STATUS_DONE;
               served       = 1'b1;
            end
         end
      end
      reply.all_empty  = (fill[v][CLASS_HIGH] == 0 && fill[v][CLASS_MEDIUM] == 0 &&
                          fill[v][CLASS_LOW] == 0);
      reply.class_full = (op.class_sel > CLASS_LOW) ? 1'b1 : ring_full(v, sel);
      return reply;
   endfunction

   // A get must never land on a ring entry that was never written
   function automatic bit head_written(int v);
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (fill[v][c] != 0) return ring_written[v][c][rd_ptr[v][c]];
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] exp_val);
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
         $display("[%0t] reply %0d: %s got %h, want %h", $time, replies_seen, what,
                  got, exp_val);
   endtask

   task automatic check_field(string what, logic [WORD_W-1:0] got,
                              logic [WORD_W-1:0] exp_val);
      if (got !== exp_val) report_mismatch(what, got, exp_val);
   endtask

   // ------------------------------------------------------------------------
   // Monitor: sample all three channels at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            replies_seen <= replies_seen + 1;
            if (predicted_replies.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_bus.data_out, '0);
            end else begin
               want = predicted_replies.pop_front();
               check_field("status", rsp_bus.status, want.status);
               check_field("data_out", rsp_bus.data_out, want.data);
               check_field("served_class", rsp_bus.served_class, want.served);
               check_field("all_empty", rsp_bus.all_empty, want.all_empty);
               check_field("class_full", rsp_bus.class_full, want.class_full);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            monitor_op.func      = req_bus.func;
            monitor_op.class_sel = req_bus.class_sel;
            monitor_op.data      = req_bus.data_in;
            predicted_replies.push_back(apply_queue_op(CHK, monitor_op));
            req_count <= req_count + 1;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index <= REG_LOW_DEPTH) depth_reg[CHK][csr_bus.index] = csr_bus.wdata;
            csr_writes <= csr_writes + 1;
         end
      end
   end

   // Watchdog: end the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers: change inputs at the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (op_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 32)) begin
            drive_op = op_backlog.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.func      <= drive_op.func;
            req_bus.class_sel <= drive_op.class_sel;
            req_bus.data_in   <= drive_op.data;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !rsp_hold && (steady || $urandom_range(0, 99) >= 32);
   end

   // Long response hold-off while requests keep coming, to fill the block
   initial begin
      rsp_hold = 1'b0;
      wait (req_count >= 700 && op_backlog.size() > 60);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (120) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic push_op(func_type func, class_type sel, logic [WORD_W-1:0] data);
      queue_op_type op;
      op.func      = func;
      op.class_sel = sel;
      op.data      = data;
      void'(apply_queue_op(GEN, op));
      op_backlog.push_back(op);
      issued++;
   endtask

   task automatic random_item(int put_pct);
      int                r;
      func_type          func;
      class_type         sel;
      logic [WORD_W-1:0] data;
      r = $urandom_range(0, 99);
      if (r < put_pct)  func = FUNC_PUT;
      else if (r < 94)  func = FUNC_GET;
      else if (r < 98)  func = FUNC_QUERY;
      else              func = FUNC_ALT_QUERY;
      if ($urandom_range(0, 39) == 0) sel = CLASS_NONE;
      else                            sel = class_type'($urandom_range(CLASS_HIGH, CLASS_LOW));
      case ($urandom_range(0, 9))
         0:       data = '0;
         1:       data = '1;
         default: data = $urandom;
      endcase
      if (func == FUNC_GET && !head_written(GEN)) func = FUNC_QUERY;
      push_op(func, sel, data);
   endtask

   task automatic write_reg(csr_idx_type idx, depth_type val);
      int target;
      target = csr_writes + 1;
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= val;
      wait (csr_writes == target);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      depth_reg[GEN][idx] = val;
   endtask

   task automatic set_depths(depth_type hi, depth_type med, depth_type lo);
      write_reg(REG_HIGH_DEPTH, hi);
      write_reg(REG_MEDIUM_DEPTH, med);
      write_reg(REG_LOW_DEPTH, lo);
   endtask

   // Wait until every issued request has its response, then let the pipe empty
   task automatic settle();
      wait (replies_seen == issued);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_QUERY;
      req_bus.class_sel = CLASS_HIGH;
      req_bus.data_in   = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = REG_HIGH_DEPTH;
      csr_bus.wdata     = DEPTH_RESET;
      issued       = 0;
      req_count    = 0;
      replies_seen = 0;
      csr_writes   = 0;
      mismatches   = 0;
      stall_cycles = 0;
      req_taken    = 1'b0;
      steady       = 1'b0;
      for (int v = 0; v < 2; v++) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            wr_ptr[v][c]    = 0;
            rd_ptr[v][c]    = 0;
            fill[v][c]      = 0;
            depth_reg[v][c] = DEPTH_RESET;
            for (int i = 0; i < RING_DEPTH; i++) begin
               ring_mem[v][c][i]     = '0;
               ring_written[v][c][i] = 1'b0;
            end
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty cases, every function and class, priority order
      push_op(FUNC_QUERY, CLASS_HIGH, '0);
      push_op(FUNC_GET, CLASS_NONE, '1);
      push_op(FUNC_PUT, CLASS_LOW, 32'h0000_0001);
      push_op(FUNC_PUT, CLASS_MEDIUM, 32'hFFFF_FFFF);
      push_op(FUNC_PUT, CLASS_HIGH, 32'h0000_0000);
      push_op(FUNC_PUT, CLASS_NONE, 32'hDEAD_BEEF);
      push_op(FUNC_ALT_QUERY, CLASS_MEDIUM, '0);
      push_op(FUNC_QUERY, CLASS_NONE, '0);
      push_op(FUNC_GET, CLASS_LOW, '0);
      push_op(FUNC_GET, CLASS_HIGH, '0);
      push_op(FUNC_GET, CLASS_MEDIUM, '0);
      push_op(FUNC_GET, CLASS_HIGH, '0);
      push_op(FUNC_PUT, CLASS_HIGH, 32'h8000_0000);
      push_op(FUNC_PUT, CLASS_LOW, 32'h7FFF_FFFF);
      push_op(FUNC_GET, CLASS_LOW, '0);
      push_op(FUNC_PUT, CLASS_MEDIUM, 32'h5555_5555);
      push_op(FUNC_GET, CLASS_NONE, '0);
      push_op(FUNC_GET, CLASS_HIGH, '0);

      // Fill every ring to the top so all entries hold written data
      repeat (RING_DEPTH) begin
         push_op(FUNC_PUT, CLASS_HIGH, $urandom);
         push_op(FUNC_PUT, CLASS_MEDIUM, $urandom);
         push_op(FUNC_PUT, CLASS_LOW, $urandom);
      end
      repeat (4) random_item($urandom_range(20, 40));
      repeat (4) random_item($urandom_range(50, 75));
      repeat (100) random_item($urandom_range(25, 75));
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_depths(5'd1, 5'd1, 5'd1);
            1: set_depths(5'd16, 5'd16, 5'd16);
            2: set_depths(5'd0, 5'd17, 5'd31);
            3: set_depths(5'd2, 5'd5, 5'd3);
            4: set_depths(depth_type'($urandom_range(1, 16)), depth_type'($urandom_range(1, 16)),
                          depth_type'($urandom_range(1, 16)));
            5: set_depths(depth_type'($urandom_range(0, 31)), depth_type'($urandom_range(0, 31)),
                          depth_type'($urandom_range(0, 31)));
            6: set_depths(5'd16, 5'd1, 5'd8);
            default: set_depths(5'd3, 5'd16, 5'd0);
         endcase
         // One phase runs without any idling on either side
         steady = (p == 1);
         // Bursts with a random put share, leaning to fill or to drain
         repeat (7) begin
            int put_pct;
            put_pct = $urandom_range(25, 75);
            repeat (25) random_item(put_pct);
         end
         settle();
      end

      repeat (10) @(posedge clock);
      if (predicted_replies.size() != 0)
         report_mismatch("replies never delivered", predicted_replies.size(), '0);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
